FILE: sv/rcsc_pkg.sv
// Shared types and constants for the reference-counted slot cache.
package rcsc_pkg;

	localparam logic [1:0] MODE_ACQUIRE = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_PURGE   = 2'd2;
	localparam logic [1:0] MODE_CLEAR   = 2'd3;

	localparam logic [2:0] STAT_HIT       = 3'd0;
	localparam logic [2:0] STAT_FILLED    = 3'd1;
	localparam logic [2:0] STAT_BAD_KEY   = 3'd2;
	localparam logic [2:0] STAT_FULL      = 3'd3;
	localparam logic [2:0] STAT_LOAD_FAIL = 3'd4;
	localparam logic [2:0] STAT_DONE      = 3'd5;

	localparam logic [6:0]  KEY_LIMIT = 7'd99;
	localparam logic [15:0] REFS_MAX  = 16'hFFFF;

	typedef struct packed {
		logic [1:0] mode;
		logic [6:0] key_index;
		logic       palette_flag;
		logic       handle_valid;
		logic [5:0] handle_slot;
		logic       load_ok;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [2:0] result_slot;
		logic       evicted;
	} rsp_t;

	// One slot entry as held in the slot memory.
	typedef struct packed {
		logic [6:0]  key;
		logic        palette;
		logic [15:0] refs;
	} entry_t;

	// Write-side controls from the sequencer to the slot store.
	typedef struct packed {
		logic wr_en;
		logic vld_set;
		logic vld_clr;
		logic vld_clr_all;
	} store_ctl_t;

	// Results of the shared compare and count unit.
	typedef struct packed {
		logic        match;
		logic        refs_zero;
		logic [15:0] refs_inc;
		logic [15:0] refs_dec;
	} cmp_res_t;

endpackage

FILE: sv/rcsc_cmp.sv
// Shared compare and count unit: key match, zero test, saturating increment and plain decrement.
module rcsc_cmp (
	input  rcsc_pkg::entry_t   entry,
	input  logic [6:0]         key,
	input  logic               palette,
	output rcsc_pkg::cmp_res_t res
);

	always_comb begin
		res.match     = (entry.key == key) && (entry.palette == palette);
		res.refs_zero = (entry.refs == 16'd0);
		res.refs_inc  = (entry.refs == rcsc_pkg::REFS_MAX) ? entry.refs : entry.refs + 16'd1;
		res.refs_dec  = entry.refs - 16'd1;
	end

endmodule

FILE: sv/rcsc_slot_store.sv
// Slot store: entry memory with registered read, and per-slot valid flags.
module rcsc_slot_store #(
	parameter int SLOTS = 8,
	parameter int IW    = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [IW-1:0]        rd_addr,
	output rcsc_pkg::entry_t     rd_data,
	input  rcsc_pkg::store_ctl_t ctl,
	input  logic [IW-1:0]        wr_addr,
	input  rcsc_pkg::entry_t     wr_data,
	output logic [SLOTS-1:0]     slot_valid
);

	rcsc_pkg::entry_t mem [SLOTS];
	rcsc_pkg::entry_t rd_data_q;
	logic [SLOTS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.vld_clr_all) begin
			valid_q <= '0;
		end else if (ctl.vld_set) begin
			valid_q[wr_addr] <= 1'b1;
		end else if (ctl.vld_clr) begin
			valid_q[wr_addr] <= 1'b0;
		end
	end

	assign rd_data    = rd_data_q;
	assign slot_valid = valid_q;

endmodule

FILE: sv/refcounted_slot_cache.sv
// Top level of the reference-counted slot cache: sequencer, scan and output register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------
//  req     | in        | req_valid, req_stall | rcsc_pkg::req_t (request)
//  rsp     | out       | rsp_valid, rsp_stall | rcsc_pkg::rsp_t (answer)
//
// Acquire and purge walk the slot memory one entry a cycle through its registered read
// port and the shared compare unit; acquire then decides in S_DECIDE. Release reads its
// slot in S_REL_RD and writes back in S_REL_WB, an ignored release skipping the write;
// a bad key or a clear goes straight to S_DONE. Reset clears every valid flag at once;
// no clearing pass is needed, as an invalid slot is never read for its contents. A
// finished answer waits in the output register under rsp_stall while the next request
// is taken; a further answer waits in its own state until that register frees.
module refcounted_slot_cache #(
	parameter int SLOTS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  rcsc_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rcsc_pkg::rsp_t   rsp
);

	// Index width into the slot table; at least one bit so a single slot still works.
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW:0]   SLOTS_C = (IW + 1)'(SLOTS);
	localparam logic [IW-1:0] LAST_C  = IW'(SLOTS - 1);
	localparam logic [6:0]    SLOTS_H = 7'(SLOTS);

	// Sequencer states.
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_REL_RD = 3'd3;
	localparam logic [2:0] S_REL_WB = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0]            state_q, state_d;
	rcsc_pkg::req_t        req_q;
	rcsc_pkg::rsp_t        res_q, res_d, rsp_q;
	logic                  res_load;
	logic                  rsp_valid_q;
	logic                  accept;
	logic                  out_load;

	// Scan pipeline: idx_q issues reads, chk_q marks the entry being checked.
	logic [IW:0]           idx_q;
	logic                  issue;
	logic                  chk_q;
	logic [IW-1:0]         chk_idx_q;
	logic                  hit_q, free_q, zero_q;
	logic [IW-1:0]         hit_idx_q, free_idx_q, zero_idx_q;
	logic [15:0]           hit_refs_q;

	logic [IW-1:0]         rd_addr;
	logic [IW-1:0]         wr_addr;
	rcsc_pkg::entry_t      wr_data;
	rcsc_pkg::entry_t      rd_data;
	rcsc_pkg::store_ctl_t  ctl;
	logic [SLOTS-1:0]      slot_valid;
	rcsc_pkg::cmp_res_t    cmp;

	logic                  chk_valid;
	logic [IW-1:0]         pick_idx;
	logic                  pick_ok;
	logic [IW-1:0]         rel_idx;
	logic                  rel_ok;
	logic [IW+2:0]         hit_wide, pick_wide;

	rcsc_slot_store #(
		.SLOTS (SLOTS),
		.IW    (IW)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.ctl        (ctl),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.slot_valid (slot_valid)
	);

	// The one compare unit sees whichever entry the read port returned this cycle.
	rcsc_cmp u_cmp (
		.entry   (rd_data),
		.key     (req_q.key_index),
		.palette (req_q.palette_flag),
		.res     (cmp)
	);

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);
	assign issue     = (state_q == S_SCAN) && (idx_q < SLOTS_C);
	assign chk_valid = slot_valid[chk_idx_q];

	// A free slot wins over evicting an unreferenced one.
	assign pick_ok  = free_q || zero_q;
	assign pick_idx = free_q ? free_idx_q : zero_idx_q;

	assign rel_idx = req_q.handle_slot[IW-1:0];
	assign rel_ok  = req_q.handle_valid && ({1'b0, req_q.handle_slot} < SLOTS_H) &&
		slot_valid[rel_idx];

	// Result slot carries the low three bits of the slot number.
	assign hit_wide  = {3'b000, hit_idx_q};
	assign pick_wide = {3'b000, pick_idx};

	assign out_load = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		rd_addr  = idx_q[IW-1:0];
		wr_addr  = pick_idx;
		wr_data  = '{key: req_q.key_index, palette: req_q.palette_flag, refs: 16'd1};
		res_load = 1'b0;
		res_d    = '{status: rcsc_pkg::STAT_DONE, result_slot: 3'd0, evicted: 1'b0};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.mode)
						rcsc_pkg::MODE_ACQUIRE: begin
							if (req.key_index > rcsc_pkg::KEY_LIMIT) begin
								res_load       = 1'b1;
								res_d.status   = rcsc_pkg::STAT_BAD_KEY;
								state_d        = S_DONE;
							end else begin
								state_d = S_SCAN;
							end
						end
						rcsc_pkg::MODE_RELEASE: begin
							state_d = S_REL_RD;
						end
						rcsc_pkg::MODE_PURGE: begin
							state_d = S_SCAN;
						end
						default: begin
							// Clear drops every slot in one go.
							ctl.vld_clr_all = 1'b1;
							res_load        = 1'b1;
							state_d         = S_DONE;
						end
					endcase
				end
			end
			S_SCAN: begin
				// Purge frees each valid unreferenced slot as the scan meets it.
				if (chk_q && (req_q.mode == rcsc_pkg::MODE_PURGE) && chk_valid &&
					cmp.refs_zero) begin
					ctl.vld_clr = 1'b1;
					wr_addr     = chk_idx_q;
				end
				if (chk_q && (chk_idx_q == LAST_C)) begin
					if (req_q.mode == rcsc_pkg::MODE_PURGE) begin
						res_load = 1'b1;
						state_d  = S_DONE;
					end else begin
						state_d = S_DECIDE;
					end
				end
			end
			S_DECIDE: begin
				res_load = 1'b1;
				state_d  = S_DONE;
				if (hit_q) begin
					ctl.wr_en         = 1'b1;
					wr_addr           = hit_idx_q;
					wr_data.refs      = hit_refs_q;
					res_d.status      = rcsc_pkg::STAT_HIT;
					res_d.result_slot = hit_wide[2:0];
				end else if (!pick_ok) begin
					res_d.status = rcsc_pkg::STAT_FULL;
				end else if (req_q.load_ok) begin
					ctl.wr_en         = 1'b1;
					ctl.vld_set       = 1'b1;
					res_d.status      = rcsc_pkg::STAT_FILLED;
					res_d.result_slot = pick_wide[2:0];
					res_d.evicted     = !free_q;
				end else begin
					// A failed load leaves the chosen slot free, evicted or not.
					ctl.vld_clr   = 1'b1;
					res_d.status  = rcsc_pkg::STAT_LOAD_FAIL;
					res_d.evicted = !free_q;
				end
			end
			S_REL_RD: begin
				rd_addr = rel_idx;
				if (rel_ok) begin
					state_d = S_REL_WB;
				end else begin
					res_load = 1'b1;
					state_d  = S_DONE;
				end
			end
			S_REL_WB: begin
				wr_addr  = rel_idx;
				wr_data  = '{key: rd_data.key, palette: rd_data.palette, refs: cmp.refs_dec};
				res_load = 1'b1;
				state_d  = S_DONE;
				if (!cmp.refs_zero) begin
					ctl.wr_en = 1'b1;
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			chk_q       <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			zero_q      <= 1'b0;
			idx_q       <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (accept) begin
				idx_q  <= '0;
				chk_q  <= 1'b0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
				zero_q <= 1'b0;
			end else if (state_q == S_SCAN) begin
				chk_q <= issue;
				if (issue) begin
					idx_q <= idx_q + (IW + 1)'(1);
				end
				// Acquire keeps the first hit, the first free slot and the first
				// valid unreferenced slot.
				if (chk_q && (req_q.mode == rcsc_pkg::MODE_ACQUIRE)) begin
					if (chk_valid && cmp.match && !hit_q) begin
						hit_q <= 1'b1;
					end
					if (!chk_valid && !free_q) begin
						free_q <= 1'b1;
					end
					if (chk_valid && cmp.refs_zero && !zero_q) begin
						zero_q <= 1'b1;
					end
				end
			end else begin
				chk_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (out_load) begin
			rsp_q <= res_q;
		end
		if (state_q == S_SCAN) begin
			chk_idx_q <= idx_q[IW-1:0];
			if (chk_q && (req_q.mode == rcsc_pkg::MODE_ACQUIRE)) begin
				if (chk_valid && cmp.match && !hit_q) begin
					hit_idx_q  <= chk_idx_q;
					hit_refs_q <= cmp.refs_inc;
				end
				if (!chk_valid && !free_q) begin
					free_idx_q <= chk_idx_q;
				end
				if (chk_valid && cmp.refs_zero && !zero_q) begin
					zero_idx_q <= chk_idx_q;
				end
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Assertions.

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.mode == rcsc_pkg::MODE_CLEAR)) |=> (slot_valid == '0))
		else $error("clear left a slot valid");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!ctl.wr_en && !ctl.vld_set))
		else $error("slot store written while idle");

	a_hit_slot_live: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DECIDE) && hit_q) |-> slot_valid[hit_idx_q])
		else $error("hit slot is not valid");

	a_fill_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DECIDE) && !hit_q && pick_ok && req_q.load_ok) |=>
		slot_valid[$past(pick_idx)])
		else $error("filled slot not marked valid");

	a_check_only_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chk_q |-> (state_q == S_SCAN))
		else $error("slot check outside the scan");

endmodule
